// ===== rtl/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared types, initial chaining words and round functions for the SHA-1 block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [4:0][31:0] hash_t;   // [0] is A / H0
  typedef logic [6:0]       rnd_t;

  localparam word_t H0_INIT = 32'h67452301;
  localparam word_t H1_INIT = 32'hEFCDAB89;
  localparam word_t H2_INIT = 32'h98BADCFE;
  localparam word_t H3_INIT = 32'h10325476;
  localparam word_t H4_INIT = 32'hC3D2E1F0;
  localparam hash_t H_INIT  = {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam rnd_t RND_LAST   = 7'd79;
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_POS     = 6'd63;

  // Control from the sequencer to the message schedule
  typedef struct packed {
    logic       load;   // shift one byte in
    logic [7:0] data;
    logic       step;   // advance one schedule word
  } sched_ctl_t;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic init;   // restore initial chaining words
    logic start;  // copy chaining words into the working registers
    logic step;   // run one round
    logic add;    // fold working registers into the chaining words
    rnd_t rnd;
  } core_ctl_t;

  function automatic word_t sha1_f(input rnd_t rnd, input word_t b, input word_t c,
                                   input word_t d);
    word_t res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40 || rnd >= 7'd60) begin
      res = b ^ c ^ d;
    end else begin
      res = (b & c) | (b & d) | (c & d);
    end
    return res;
  endfunction

  function automatic word_t sha1_k(input rnd_t rnd);
    word_t res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1md_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// 16-word shift line: takes message bytes, then yields one W word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_sched
  import sha1md_pkg::*;
(
  input  wire        clk,
  input  sched_ctl_t ctl,
  output word_t      w_top
);

  logic [511:0] blk_r;
  word_t        w_new;

  // oldest word sits at the top; word k at [511-32k -: 32]
  assign w_top = blk_r[511:480];

  always_comb begin
    w_new = blk_r[511-32*13 -: 32] ^ blk_r[511-32*8 -: 32] ^
            blk_r[511-32*2 -: 32] ^ blk_r[511:480];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      blk_r <= {blk_r[503:0], ctl.data};
    end else if (ctl.step) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1md_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working registers A..E, one compression round per cycle while step is set, chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_core
  import sha1md_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  core_ctl_t ctl,
  input  word_t     w,
  output hash_t     h
);

  hash_t h_r;
  hash_t v_r;
  hash_t v_nxt;
  word_t t;

  assign h = h_r;

  always_comb begin
    t = {v_r[0][26:0], v_r[0][31:27]} + sha1_f(ctl.rnd, v_r[1], v_r[2], v_r[3]) +
        v_r[4] + w + sha1_k(ctl.rnd);
    v_nxt[0] = t;
    v_nxt[1] = v_r[0];
    v_nxt[2] = {v_r[1][1:0], v_r[1][31:2]};
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= H_INIT;
    end else if (ctl.init) begin
      h_r <= H_INIT;
    end else if (ctl.add) begin
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  // working registers: payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v_r <= h_r;
    end else if (ctl.step) begin
      v_r <= v_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_message_digest_top.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 hasher: one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Input: a byte that does not fill a block is absorbed while idle; a byte that
//   fills the 64-byte block starts the rounds and chaining add, stalling input.
// End of message: padding shifts in one byte per cycle outside compressions,
//   spilling into a second block when needed; each final block is compressed,
//   then the result is loaded. The shared round unit's loop sets the rate.
// Reset (rst_n low, synchronous): initial chaining words, zero count and flag, no result.
`default_nettype none

module sha1_message_digest_top
  import sha1md_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_message_byte,
  input  wire         in_byte_present,
  input  wire         in_end_of_message,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word_0,
  output logic [31:0] out_digest_word_1,
  output logic [31:0] out_digest_word_2,
  output logic [31:0] out_digest_word_3,
  output logic [31:0] out_digest_word_4,
  output logic        out_message_too_long
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;       // where to go after a compression
  rnd_t        rnd_r, rnd_nxt;
  logic [5:0]  pos_r, pos_nxt;       // byte position inside the block while padding
  logic        extra_r, extra_nxt;   // padding spills into a second block
  logic [60:0] cnt_r, cnt_nxt;       // message length in bytes
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  hash_t       out_dig_r, out_dig_nxt;
  logic        out_tl_r, out_tl_nxt;

  logic [61:0] cnt_inc;
  logic        take;
  logic        ovf_after;
  logic [63:0] len_bits;

  sched_ctl_t  sctl;
  core_ctl_t   cctl;
  word_t       w_top;
  hash_t       h;

  sha1md_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_top (w_top)
  );

  sha1md_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .w     (w_top),
    .h     (h)
  );

  // Take beats only while idle; the output register decouples the result side.
  assign in_stall = (state_r != S_IDLE);

  assign out_valid            = out_valid_r;
  assign out_digest_word_0    = out_dig_r[0];
  assign out_digest_word_1    = out_dig_r[1];
  assign out_digest_word_2    = out_dig_r[2];
  assign out_digest_word_3    = out_dig_r[3];
  assign out_digest_word_4    = out_dig_r[4];
  assign out_message_too_long = out_tl_r;

  assign cnt_inc   = {1'b0, cnt_r} + 62'd1;
  assign take      = in_byte_present && !ovf_r;
  assign ovf_after = ovf_r || (take && cnt_inc[61]);
  assign len_bits  = {cnt_r, 3'b000};

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    extra_nxt     = extra_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;   // drop once taken
    out_dig_nxt   = out_dig_r;
    out_tl_nxt    = out_tl_r;
    sctl          = '0;
    cctl          = '0;
    cctl.rnd      = rnd_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Absorb the byte unless the count already overflowed.
          if (take) begin
            sctl.load = 1'b1;
            sctl.data = in_message_byte;
            cnt_nxt   = cnt_inc[60:0];
            ovf_nxt   = cnt_inc[61];
          end
          pos_nxt = take ? cnt_inc[5:0] : cnt_r[5:0];
          if (in_end_of_message && ovf_after) begin
            state_nxt = S_DONE;
          end else if (take && cnt_r[5:0] == LAST_POS) begin
            // block full: compress, then pad if this beat also ends the message
            cctl.start = 1'b1;
            rnd_nxt    = '0;
            state_nxt  = S_ROUND;
            ret_nxt    = in_end_of_message ? S_PAD_MARK : S_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD_MARK;
          end
        end
      end

      S_PAD_MARK: begin
        sctl.load = 1'b1;
        sctl.data = PAD_MARK_BYTE;
        pos_nxt   = pos_r + 6'd1;
        extra_nxt = (pos_r >= LEN_POS);
        if (pos_r == LAST_POS) begin
          cctl.start = 1'b1;
          rnd_nxt    = '0;
          extra_nxt  = 1'b0;
          state_nxt  = S_ROUND;
          ret_nxt    = S_PAD_ZERO;
        end else begin
          state_nxt = S_PAD_ZERO;
        end
      end

      S_PAD_ZERO: begin
        if (pos_r == LEN_POS && !extra_r) begin
          state_nxt = S_PAD_LEN;
        end else begin
          sctl.load = 1'b1;
          sctl.data = 8'h00;
          pos_nxt   = pos_r + 6'd1;
          if (pos_r == LAST_POS) begin
            cctl.start = 1'b1;
            rnd_nxt    = '0;
            extra_nxt  = 1'b0;
            state_nxt  = S_ROUND;
            ret_nxt    = S_PAD_ZERO;
          end
        end
      end

      S_PAD_LEN: begin
        // big-endian bit count, one byte per cycle
        sctl.load = 1'b1;
        sctl.data = 8'(len_bits >> {~pos_r[2:0], 3'b000});
        pos_nxt   = pos_r + 6'd1;
        if (pos_r == LAST_POS) begin
          cctl.start = 1'b1;
          rnd_nxt    = '0;
          state_nxt  = S_ROUND;
          ret_nxt    = S_DONE;
        end
      end

      S_ROUND: begin
        cctl.step = 1'b1;
        sctl.step = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == RND_LAST) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        cctl.add  = 1'b1;
        state_nxt = ret_r;
      end

      S_DONE: begin
        // Hold until the output register is free, then restart the message.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dig_nxt   = ovf_r ? '0 : h;
          out_tl_nxt    = ovf_r;
          cctl.init     = 1'b1;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      rnd_r       <= '0;
      pos_r       <= '0;
      extra_r     <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      extra_r     <= extra_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_dig_r <= out_dig_nxt;
    out_tl_r  <= out_tl_nxt;
  end

  // Round counter never runs past the last round.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> rnd_r <= RND_LAST)
    else $error("round counter out of range");

  // The last round always hands over to the chaining add.
  a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && rnd_r == RND_LAST |=> state_r == S_ADD)
    else $error("last round not followed by chaining add");

  // A new result only comes out of the finishing state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside finishing state");

  // Length bytes fill the last eight positions of the block.
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAD_LEN |-> pos_r[5:3] == 3'b111)
    else $error("length bytes misplaced");

  // A flagged result carries an all-zero digest.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tl_r |-> out_dig_r == '0)
    else $error("overflowed result carries a digest");

endmodule

`default_nettype wire

// ===== sim/tb_sha1_message_digest_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Feeds byte-serial messages through the hasher. Each digest beat is checked
// against a local SHA-1 model, or against a known digest in the directed rows.
// ----------------------------------------------------------------------------

module tb_sha1_message_digest_top;
  import sha1md_pkg::*;

  // --------------------------------------------------------------------------
  // Types and constants
  // --------------------------------------------------------------------------
  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
    word_t w4;
    logic  too_long;
  } digest_t;

  // One directed beat. When typed is set, the digest in exp is the expected
  // result and the model is not consulted for it.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       typed;
    digest_t    exp;
  } dir_row_t;

  localparam digest_t NO_DIGEST    = '0;
  localparam digest_t DIGEST_EMPTY = '{32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                       32'h95601890, 32'hafd80709, 1'b0};
  localparam digest_t DIGEST_ABC   = '{32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                       32'h7850c26c, 32'h9cd0d89d, 1'b0};

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty message straight out of reset
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    // bare beat: no byte, no end, must change nothing
    '{8'hA5, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    // bare end marker; the byte lane carries junk and must be ignored
    '{8'hFF, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    // "abc" closed on its last byte
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
    // "abc" with a bare beat inside, closed by a bare end marker
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h5A, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
    // single-byte messages at the byte extremes
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    // mixed extremes, including the pad marker value as data
    '{8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h7F, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    // back-to-back empty message after a real one
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
  };

  // Message lengths around the padding and block boundaries
  localparam int BOUNDARY_LENS [8] = '{54, 55, 56, 57, 62, 63, 64, 65};

  localparam int RANDOM_ITEMS = 532;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 300;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [7:0]  in_message_byte   = 8'h00;
  logic        in_byte_present   = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [31:0] out_digest_word_0;
  logic [31:0] out_digest_word_1;
  logic [31:0] out_digest_word_2;
  logic [31:0] out_digest_word_3;
  logic [31:0] out_digest_word_4;
  logic        out_message_too_long;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sha1_message_digest_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_message_byte      (in_message_byte),
    .in_byte_present      (in_byte_present),
    .in_end_of_message    (in_end_of_message),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digest_word_0    (out_digest_word_0),
    .out_digest_word_1    (out_digest_word_1),
    .out_digest_word_2    (out_digest_word_2),
    .out_digest_word_3    (out_digest_word_3),
    .out_digest_word_4    (out_digest_word_4),
    .out_message_too_long (out_message_too_long)
  );

  // --------------------------------------------------------------------------
  // Shared run control
  // --------------------------------------------------------------------------
  digest_t     pending_digests [$];  // digests owed by the DUT, oldest first
  int          err_cnt    = 0;
  int          rand_items = 0;
  bit          quiet      = 1'b0;    // suppress random idling on both sides
  bit          hold_req   = 1'b0;    // ask the receiver for one long hold-off
  bit          hold_taken = 1'b0;
  int          hold_left  = 0;
  digest_t     front_digest;

  // --------------------------------------------------------------------------
  // SHA-1 model state: chaining words, block buffer, fill and bit count
  // --------------------------------------------------------------------------
  word_t       hash_words [5];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_bits;
  logic        msg_overflow;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_message();
    hash_words   = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
    blk_fill     = 0;
    msg_bits     = '0;
    msg_overflow = 1'b0;
  endtask

  // Run the 80 rounds over the buffered block and fold into the chain
  task automatic compress_block();
    word_t w [80];
    word_t a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + w[i] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
    blk_fill = 0;
  endtask

  // Advance the model by one accepted beat; got is set when a digest is due.
  // The bit-count wrap needs 2^61 bytes, so the flagged path is modeled but
  // lies far beyond any run length.
  task automatic predict_digest(input logic [7:0] data, input logic present,
                                input logic eom, output bit got, output digest_t res);
    got = 1'b0;
    res = '0;
    if (present && !msg_overflow) begin
      blk_bytes[blk_fill] = data;
      blk_fill++;
      msg_bits += 64'd8;
      if (msg_bits == '0) msg_overflow = 1'b1;
      if (blk_fill == 64) compress_block();
    end
    if (eom) begin
      got = 1'b1;
      if (msg_overflow) begin
        res.too_long = 1'b1;
      end else begin
        blk_bytes[blk_fill] = PAD_MARK_BYTE;
        blk_fill++;
        if (blk_fill > 56) begin
          while (blk_fill < 64) begin
            blk_bytes[blk_fill] = 8'h00;
            blk_fill++;
          end
          compress_block();
        end
        while (blk_fill < 56) begin
          blk_bytes[blk_fill] = 8'h00;
          blk_fill++;
        end
        for (int i = 0; i < 8; i++) begin
          blk_bytes[56+i] = msg_bits[63-8*i -: 8];
        end
        compress_block();
        res = '{hash_words[0], hash_words[1], hash_words[2], hash_words[3],
                hash_words[4], 1'b0};
      end
      restart_message();
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: offer one beat, hold it until accepted, then update the model
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] data, input logic present, input logic eom,
                           input logic typed, input digest_t typed_exp);
    bit      got;
    digest_t pred;
    @(negedge clk);
    // random idle cycles ahead of the beat
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_message_byte   <= data;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    // hold the payload until a rising edge with stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(data, present, eom, got, pred);
    if (got) pending_digests.push_back(typed ? typed_exp : pred);
  endtask

  // Random message of len bytes, with stray bare beats sprinkled in; closed
  // either on its last byte or by a separate bare end marker
  task automatic send_message(input int len);
    bit bare_end;
    bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
        rand_items++;
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1),
                1'b0, NO_DIGEST);
      rand_items++;
    end
    if (bare_end) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
      rand_items++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall at random, plus one long hold-off on request so the
  // output register fills and the DUT backs up into its input
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  // Compare every accepted digest beat with the oldest pending digest
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        $error("digest beat with nothing pending: %h %h %h %h %h too_long=%b",
               out_digest_word_0, out_digest_word_1, out_digest_word_2,
               out_digest_word_3, out_digest_word_4, out_message_too_long);
        err_cnt++;
      end else begin
        front_digest = pending_digests.pop_front();
        check_field("digest_word_0", front_digest.w0, out_digest_word_0);
        check_field("digest_word_1", front_digest.w1, out_digest_word_1);
        check_field("digest_word_2", front_digest.w2, out_digest_word_2);
        check_field("digest_word_3", front_digest.w3, out_digest_word_3);
        check_field("digest_word_4", front_digest.w4, out_digest_word_4);
        check_field("message_too_long", 32'(front_digest.too_long),
                    32'(out_message_too_long));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int msg_idx;
    int wait_cnt;
    restart_message();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_beat(DIR_TAB[r].data, DIR_TAB[r].present, DIR_TAB[r].eom,
                DIR_TAB[r].typed, DIR_TAB[r].exp);
    end

    // sweep the lengths around the point where padding spills into a second block
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    // bulk: mostly short messages, some at the boundaries; request the long
    // receiver hold-off at the start and run a stretch without idling
    hold_req = 1'b1;
    msg_idx  = 0;
    while (rand_items < RANDOM_ITEMS) begin
      quiet = (msg_idx >= 8) && (msg_idx < 20);
      if ($urandom_range(0, 99) < 15) begin
        send_message(BOUNDARY_LENS[$urandom_range(0, 7)]);
      end else begin
        send_message($urandom_range(0, 12));
      end
      msg_idx++;
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;

    // drain pending digests, then let the pipeline settle
    wait_cnt = 0;
    while (pending_digests.size() > 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (pending_digests.size() > 0) begin
      $error("%0d digests never arrived", pending_digests.size());
      err_cnt++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sha1_message_digest_top.f =====
rtl/sha1md_pkg.sv
rtl/sha1md_sched.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest_top.sv
sim/tb_sha1_message_digest_top.sv
